// File: design/lbr_pkg.sv
// Package for the LSB-first bit reader: store geometry, request layout,
// action codes and controller-to-datapath command types. No dependencies.
`default_nettype none

package lbr_pkg;

    // Must be a power of two (16 .. 1048576); positions wrap by masking.
    localparam int STORE_BYTES = 4096;
    localparam int STORE_AW    = $clog2(STORE_BYTES);
    localparam int NUM_BANKS   = 8;
    localparam int BANK_SEL_W  = 3;
    localparam int ROW_AW      = STORE_AW - BANK_SEL_W;
    localparam int BANK_ROWS   = STORE_BYTES / NUM_BANKS;

    localparam int IN_W  = 56;
    localparam int OUT_W = 64;

    localparam logic [2:0] ACT_LOAD      = 3'd0;
    localparam logic [2:0] ACT_GET       = 3'd1;
    localparam logic [2:0] ACT_ADV_BITS  = 3'd2;
    localparam logic [2:0] ACT_ADV_BYTES = 3'd3;
    localparam logic [2:0] ACT_ALIGN     = 3'd4;
    localparam logic [2:0] ACT_REWIND    = 3'd5;

    typedef struct packed {
        logic [5:0]  pad;
        logic [15:0] skip_count;
        logic        advance_after;
        logic [1:0]  width_select;
        logic [7:0]  get_count;
        logic [7:0]  load_byte;
        logic [11:0] load_address;
        logic [2:0]  action;
    } in_item_t;

    typedef struct packed {
        logic take;     // request accepted this cycle
        logic in_top;   // low bytes are in, ninth byte being read
        logic top_hold; // ninth byte stays addressed until the result loads
        logic finish;   // result register loads this cycle
    } lbr_cmd_t;

    typedef struct packed {
        logic is_get;
    } lbr_status_t;

endpackage

`default_nettype wire

// File: design/lbr_ctrl.sv
// Controller for the LSB-first bit reader: request sequencing and result valid.
// Depends on lbr_pkg.
`default_nettype none

module lbr_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire lbr_pkg::lbr_status_t status,
    output lbr_pkg::lbr_cmd_t        cmd
);
    import lbr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TOP  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign s_tready     = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid     = out_valid_reg;
    assign cmd.take     = s_tvalid && s_tready;
    assign cmd.in_top   = (state_reg == ST_TOP);
    assign cmd.top_hold = (state_reg == ST_OUT);
    assign cmd.finish   = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.take && status.is_get) begin
                    state_next = ST_TOP;
                end
            end
            ST_TOP: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (cmd.finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: design/lbr_datapath.sv
// Datapath for the LSB-first bit reader: eight-bank byte store, position and
// offset registers, shift and mask of the result. Depends on lbr_pkg.
`default_nettype none

module lbr_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [lbr_pkg::IN_W-1:0] s_tdata,
    input  wire lbr_pkg::lbr_cmd_t    cmd,
    output lbr_pkg::lbr_status_t      status,
    output logic [lbr_pkg::OUT_W-1:0] m_tdata
);
    import lbr_pkg::*;

    in_item_t req;

    logic [STORE_AW-1:0]   pos_reg, pos_next;
    logic [2:0]            off_reg, off_next;
    logic [7:0]            cnt_reg;
    logic [1:0]            wsel_reg;
    logic                  adv_reg;
    logic [63:0]           low_reg;
    logic [OUT_W-1:0]      out_reg;

    logic [7:0]            bank_mem [NUM_BANKS][BANK_ROWS];
    logic [7:0]            rdata    [NUM_BANKS];
    logic [ROW_AW-1:0]     raddr    [NUM_BANKS];
    logic [STORE_AW-1:0]   waddr;
    logic                  wen;

    logic [ROW_AW-1:0]     row;
    logic [2:0]            p0;
    logic [63:0]           low_now;
    logic [127:0]          joined;
    logic [63:0]           shifted;
    logic [7:0]            cm1;
    logic [5:0]            wmask;
    logic [6:0]            n_bits;
    logic [63:0]           mask;
    logic [16:0]           total;
    logic [15:0]           move_cnt;

    assign req        = in_item_t'(s_tdata);
    assign status.is_get = (req.action == ACT_GET);
    assign m_tdata    = out_reg;

    assign row = pos_reg[STORE_AW-1:BANK_SEL_W];
    assign p0  = pos_reg[BANK_SEL_W-1:0];

    // bank b holds byte pos+k with k = (b - p0) mod 8; banks below p0 sit on the next row
    always_comb begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            if ((BANK_SEL_W'(b) < p0) ||
                ((cmd.in_top || cmd.top_hold) && (BANK_SEL_W'(b) == p0))) begin
                raddr[b] = row + ROW_AW'(1);
            end else begin
                raddr[b] = row;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_BANKS; k++) begin
            low_now[8*k +: 8] = rdata[p0 + BANK_SEL_W'(k)];
        end
    end

    assign waddr = STORE_AW'(32'(req.load_address));
    assign wen   = cmd.take && (req.action == ACT_LOAD);

    genvar gb;
    generate
        for (gb = 0; gb < NUM_BANKS; gb++) begin : g_bank
            always_ff @(posedge aclk) begin
                if (wen && (waddr[BANK_SEL_W-1:0] == BANK_SEL_W'(gb))) begin
                    bank_mem[gb][waddr[STORE_AW-1:BANK_SEL_W]] <= req.load_byte;
                end
                rdata[gb] <= bank_mem[gb][raddr[gb]];
            end
        end
    endgenerate

    // extract: ninth byte is in bank p0 during the output state
    assign joined  = {56'd0, rdata[p0], low_reg};
    assign shifted = joined[7'(off_reg) +: 64];
    assign cm1     = cnt_reg - 8'd1;
    assign wmask   = 6'((7'd8 << wsel_reg) - 7'd1);
    assign n_bits  = 7'(cm1[5:0] & wmask) + 7'd1;
    assign mask    = 64'hFFFF_FFFF_FFFF_FFFF >> (7'd64 - n_bits);

    // shared bit-advance adder
    assign move_cnt = cmd.finish ? 16'(cnt_reg) : req.skip_count;
    assign total    = 17'(off_reg) + 17'(move_cnt);

    always_comb begin
        pos_next = pos_reg;
        off_next = off_reg;
        if (cmd.take) begin
            case (req.action)
                ACT_ADV_BITS: begin
                    pos_next = STORE_AW'(32'(pos_reg) + 32'(total[16:3]));
                    off_next = total[2:0];
                end
                ACT_ADV_BYTES: begin
                    pos_next = STORE_AW'(32'(pos_reg) + 32'(req.skip_count));
                end
                ACT_ALIGN: begin
                    if (off_reg != 3'd0) begin
                        pos_next = pos_reg + STORE_AW'(1);
                        off_next = 3'd0;
                    end
                end
                ACT_REWIND: begin
                    pos_next = '0;
                    off_next = 3'd0;
                end
                default: begin
                    pos_next = pos_reg;
                end
            endcase
        end else if (cmd.finish && adv_reg) begin
            pos_next = STORE_AW'(32'(pos_reg) + 32'(total[16:3]));
            off_next = total[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            off_reg <= 3'd0;
        end else begin
            pos_reg <= pos_next;
            off_reg <= off_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            cnt_reg  <= req.get_count;
            wsel_reg <= req.width_select;
            adv_reg  <= req.advance_after;
        end
        if (cmd.in_top) begin
            low_reg <= low_now;
        end
        if (cmd.finish) begin
            out_reg <= (cnt_reg == 8'd0) ? 64'd0 : (shifted & mask);
        end
    end

endmodule

`default_nettype wire

// File: design/lsb_first_bit_reader.sv
// LSB-first bit reader top level: controller plus datapath.
// Get request: low bytes read on acceptance, ninth byte in a second store read, result
// registered after it; next request taken the cycle after, none while a get is in flight.
// A result still held on m_tdata stalls the next get until m_tready frees the register.
// Load, advance, align and rewind requests complete in the accepting cycle.
// Reset (aresetn low, synchronous) clears position, offset and control; store is not cleared.
`default_nettype none

module lsb_first_bit_reader (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // action[2:0], load_address[14:3], load_byte[22:15], get_count[30:23],
    // width_select[32:31], advance_after[33], skip_count[49:34], zero [55:50]
    input  wire logic [lbr_pkg::IN_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // bits_value[63:0]
    output logic [lbr_pkg::OUT_W-1:0]     m_tdata
);
    import lbr_pkg::*;

    lbr_cmd_t    cmd;
    lbr_status_t status;

    lbr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lbr_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata)
    );

endmodule

`default_nettype wire
